### sv/tbrl_pkg.sv
// Shared widths, register indexes and interface structs for the token bucket rate limiter.
package tbrl_pkg;

   // Fixed-point and field widths.
   localparam int FRAC_BITS  = 24;
   localparam int TIME_BITS  = 48;
   localparam int BURST_W    = 16;
   localparam int PERM_W     = BURST_W + FRAC_BITS;
   localparam int RATE_W     = 32;
   localparam int WAIT_W     = 32;
   localparam int TOUT_W     = 31;
   localparam int PCOUNT_W   = 16;

   // Width of the shared adder: elapsed time, saturating product and divider remainder.
   localparam int ALU_W_A    = (TIME_BITS > PERM_W + 2) ? TIME_BITS : PERM_W + 2;
   localparam int ALU_W      = (ALU_W_A > RATE_W + 1) ? ALU_W_A : RATE_W + 1;

   // Iteration counter covers the rate bits and the quotient bits.
   localparam int CNT_W      = $clog2(RATE_W);

   // Configuration port.
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_REFILL_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_BURST_LIMIT = CSR_IDX_W'(1);

   // Operation codes.
   localparam logic OP_TRY     = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   typedef struct packed {
      logic                 operation;
      logic [TIME_BITS-1:0] now_us;
      logic [PCOUNT_W-1:0]  permits;
      logic [TOUT_W-1:0]    max_wait_us;
   } req_type;

   typedef struct packed {
      logic              granted;
      logic [WAIT_W-1:0] wait_us;
      logic              wait_fits;
   } rsp_type;

   typedef struct packed {
      logic [RATE_W-1:0]  rate;
      logic [BURST_W-1:0] burst;
      logic               burst_wr;
      logic [BURST_W-1:0] burst_new;
   } cfg_type;

endpackage

### sv/tbrl_alu.sv
// Shared add/subtract unit with carry out, used by the arithmetic steps of the sequencer.
module tbrl_alu (
   input  logic [tbrl_pkg::ALU_W-1:0] alu_a,
   input  logic [tbrl_pkg::ALU_W-1:0] alu_b,
   input  logic                       alu_sub,
   input  logic                       alu_cin,
   output logic [tbrl_pkg::ALU_W-1:0] alu_sum,
   output logic                       alu_cout
);
   import tbrl_pkg::*;

   logic [ALU_W-1:0] b_op;
   logic [ALU_W:0]   full_sum;

   // With subtract and carry in, the carry out means a is not below b.
   assign b_op     = alu_sub ? ~alu_b : alu_b;
   assign full_sum = {1'b0, alu_a} + {1'b0, b_op} + {{ALU_W{1'b0}}, alu_cin};
   assign alu_sum  = full_sum[ALU_W-1:0];
   assign alu_cout = full_sum[ALU_W];

endmodule

### sv/tbrl_core.sv
// Sequencer and datapath registers: refill, grant check and wait division on one shared adder.
module tbrl_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  tbrl_pkg::req_type req,
   input  tbrl_pkg::cfg_type cfg,
   input  logic              out_free,
   output logic              idle,
   output logic              done,
   output tbrl_pkg::rsp_type rsp
);
   import tbrl_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE = 4'd0;
   localparam logic [ST_W-1:0] S_ELAP = 4'd1;
   localparam logic [ST_W-1:0] S_PREP = 4'd2;
   localparam logic [ST_W-1:0] S_MUL  = 4'd3;
   localparam logic [ST_W-1:0] S_SUM  = 4'd4;
   localparam logic [ST_W-1:0] S_CAP  = 4'd5;
   localparam logic [ST_W-1:0] S_CMP  = 4'd6;
   localparam logic [ST_W-1:0] S_DIFF = 4'd7;
   localparam logic [ST_W-1:0] S_NUM  = 4'd8;
   localparam logic [ST_W-1:0] S_SATC = 4'd9;
   localparam logic [ST_W-1:0] S_DIV  = 4'd10;
   localparam logic [ST_W-1:0] S_FIT  = 4'd11;
   localparam logic [ST_W-1:0] S_DONE = 4'd12;

   // Control and architectural state.
   logic [ST_W-1:0]      state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PERM_W-1:0]    stored_ff, stored_in;
   logic [TIME_BITS-1:0] last_ff, last_in;

   // Per-transaction working registers.
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [PERM_W-1:0]    need_ff, need_in;
   logic [TOUT_W-1:0]    timeout_ff, timeout_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [ALU_W-1:0]     acc_ff, acc_in;
   logic [RATE_W-1:0]    rem_ff, rem_in;
   logic [WAIT_W-1:0]    q_ff, q_in;
   logic                 granted_ff, granted_in;
   logic                 fits_ff, fits_in;

   // Shared unit operands.
   logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
   logic             alu_sub, alu_cin, alu_cout;

   logic [PERM_W-1:0] cap;
   logic [PERM_W-1:0] cap_new;
   logic              rate_zero;
   logic              elapsed_big;
   logic [RATE_W:0]   div_trial;

   tbrl_alu u_alu (
      .alu_a    (alu_a),
      .alu_b    (alu_b),
      .alu_sub  (alu_sub),
      .alu_cin  (alu_cin),
      .alu_sum  (alu_sum),
      .alu_cout (alu_cout)
   );

   assign cap         = {cfg.burst, {FRAC_BITS{1'b0}}};
   assign cap_new     = {cfg.burst_new, {FRAC_BITS{1'b0}}};
   assign rate_zero   = (cfg.rate == '0);
   // Elapsed time at or above one whole bucket scale overflows any nonzero rate.
   assign elapsed_big = ((ALU_W'(elapsed_ff) >> PERM_W) != '0);
   assign div_trial   = {rem_ff, q_ff[WAIT_W-1]};

   // Operand selection for the shared adder.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      alu_cin = 1'b0;
      unique case (state_ff)
         S_ELAP: begin
            alu_a   = ALU_W'(now_ff);
            alu_b   = ALU_W'(last_ff);
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         S_MUL: begin
            alu_a = acc_ff << 1;
            alu_b = cfg.rate[cnt_ff] ? ALU_W'(elapsed_ff) : '0;
         end
         S_SUM: begin
            alu_a = ALU_W'(stored_ff);
            alu_b = acc_ff;
         end
         S_CAP: begin
            alu_a   = acc_ff;
            alu_b   = ALU_W'(cap);
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         S_CMP: begin
            alu_a   = ALU_W'(stored_ff);
            alu_b   = ALU_W'(need_ff);
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         S_DIFF: begin
            // Needed minus stored, less one, so that the quotient rounds up.
            alu_a   = ALU_W'(need_ff);
            alu_b   = ALU_W'(stored_ff);
            alu_sub = 1'b1;
         end
         S_NUM: begin
            alu_a = acc_ff;
            alu_b = ALU_W'(cfg.rate);
         end
         S_SATC: begin
            alu_a   = acc_ff >> WAIT_W;
            alu_b   = ALU_W'(cfg.rate);
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         S_DIV: begin
            alu_a   = ALU_W'(div_trial);
            alu_b   = ALU_W'(cfg.rate);
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         S_FIT: begin
            alu_a   = ALU_W'(timeout_ff);
            alu_b   = ALU_W'(q_ff);
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   // Sequencer next state and register updates.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      stored_in  = stored_ff;
      last_in    = last_ff;
      now_in     = now_ff;
      need_in    = need_ff;
      timeout_in = timeout_ff;
      elapsed_in = elapsed_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      granted_in = granted_ff;
      fits_in    = fits_ff;
      unique case (state_ff)
         S_IDLE: begin
            // A smaller burst limit clamps the bucket at once.
            if (cfg.burst_wr && (stored_ff > cap_new)) begin
               stored_in = cap_new;
            end
            if (start) begin
               now_in     = req.now_us;
               need_in    = {req.permits, {FRAC_BITS{1'b0}}};
               timeout_in = (req.operation == OP_TIMEOUT) ? req.max_wait_us : '0;
               state_in   = S_ELAP;
            end
         end
         S_ELAP: begin
            // Time that went backwards counts as no time at all.
            elapsed_in = alu_cout ? alu_sum[TIME_BITS-1:0] : '0;
            last_in    = now_ff;
            state_in   = S_PREP;
         end
         S_PREP: begin
            if (rate_zero || (elapsed_ff == '0)) begin
               state_in = S_CMP;
            end else if (elapsed_big) begin
               stored_in = cap;
               state_in  = S_CMP;
            end else begin
               acc_in   = '0;
               cnt_in   = CNT_W'(RATE_W - 1);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // Shift-add over the rate bits, MSB first; stop once past any possible room.
            acc_in = alu_sum;
            if ((alu_sum >> PERM_W) != '0) begin
               stored_in = cap;
               state_in  = S_CMP;
            end else if (cnt_ff == '0) begin
               state_in = S_SUM;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_SUM: begin
            acc_in   = alu_sum;
            state_in = S_CAP;
         end
         S_CAP: begin
            stored_in = alu_cout ? cap : acc_ff[PERM_W-1:0];
            state_in  = S_CMP;
         end
         S_CMP: begin
            if (alu_cout) begin
               stored_in  = alu_sum[PERM_W-1:0];
               granted_in = 1'b1;
               q_in       = '0;
               fits_in    = 1'b1;
               state_in   = S_DONE;
            end else if (rate_zero) begin
               q_in     = '1;
               state_in = S_FIT;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            acc_in   = alu_sum;
            state_in = S_NUM;
         end
         S_NUM: begin
            acc_in   = alu_sum;
            state_in = S_SATC;
         end
         S_SATC: begin
            // A high part not below the rate means the quotient overflows the wait field.
            if (alu_cout) begin
               q_in     = '1;
               state_in = S_FIT;
            end else begin
               rem_in   = RATE_W'(acc_ff >> WAIT_W);
               q_in     = acc_ff[WAIT_W-1:0];
               cnt_in   = CNT_W'(WAIT_W - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Restoring division, one quotient bit per cycle.
            rem_in = alu_cout ? alu_sum[RATE_W-1:0] : div_trial[RATE_W-1:0];
            q_in   = {q_ff[WAIT_W-2:0], alu_cout};
            if (cnt_ff == '0) begin
               state_in = S_FIT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FIT: begin
            granted_in = 1'b0;
            fits_in    = alu_cout;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and bucket state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         stored_ff <= '0;
         last_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         stored_ff <= stored_in;
         last_ff   <= last_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      need_ff    <= need_in;
      timeout_ff <= timeout_in;
      elapsed_ff <= elapsed_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      granted_ff <= granted_in;
      fits_ff    <= fits_in;
   end

   assign idle          = (state_ff == S_IDLE);
   assign done          = (state_ff == S_DONE);
   assign rsp.granted   = granted_ff;
   assign rsp.wait_us   = q_ff;
   assign rsp.wait_fits = fits_ff;

endmodule

### sv/token_bucket_rate_limiter.sv
// Top level of the token bucket rate limiter: handshakes, configuration registers, output register.
//
//   Channel   Direction  Handshake              Payload
//   req_*     in         req_valid / req_stall  operation, now_us, permits, max_wait_us
//   rsp_*     out        rsp_valid / rsp_stall  granted, wait_us, wait_fits
//   csr_*     in         csr_valid / csr_ready  csr_index, csr_data
//
// A request passes the elapsed-time, prepare and compare steps; a refill adds the shift-add
// multiply over the rate bits, stopped early once past any room, then add and cap; a denial adds
// the fit check, and with a nonzero rate also the difference, numerator, overflow and divider steps.
// Reset is synchronous and clears the bucket, the last time stamp and both registers.
// req_stall is high while a request is being worked on or its result cannot leave the core;
// the next request can be accepted in the cycle after the result register is loaded.
module token_bucket_rate_limiter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [tbrl_pkg::TIME_BITS-1:0]       req_now_us,
   input  logic [tbrl_pkg::PCOUNT_W-1:0]        req_permits,
   input  logic [tbrl_pkg::TOUT_W-1:0]          req_max_wait_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_granted,
   output logic [tbrl_pkg::WAIT_W-1:0]          rsp_wait_us,
   output logic                                 rsp_wait_fits,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tbrl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tbrl_pkg::CSR_DATA_W-1:0]      csr_data
);
   import tbrl_pkg::*;

   logic               core_idle;
   logic               core_done;
   logic               out_free;
   logic               start;
   logic               csr_wr;
   req_type            req;
   rsp_type            core_rsp;
   cfg_type            cfg;

   logic [RATE_W-1:0]  rate_ff;
   logic [BURST_W-1:0] burst_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // Request transaction enters only while the core is idle.
   assign req_stall       = !core_idle;
   assign start           = req_valid && !req_stall;
   assign req.operation   = req_operation;
   assign req.now_us      = req_now_us;
   assign req.permits     = req_permits;
   assign req.max_wait_us = req_max_wait_us;

   // Configuration writes.
   assign csr_ready = core_idle;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= '0;
         burst_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_REFILL_RATE: rate_ff  <= csr_data[RATE_W-1:0];
            REG_BURST_LIMIT: burst_ff <= csr_data[BURST_W-1:0];
            default:         rate_ff  <= rate_ff;
         endcase
      end
   end

   assign cfg.rate      = rate_ff;
   assign cfg.burst     = burst_ff;
   assign cfg.burst_wr  = csr_wr && (csr_index == REG_BURST_LIMIT);
   assign cfg.burst_new = csr_data[BURST_W-1:0];

   tbrl_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req),
      .cfg      (cfg),
      .out_free (out_free),
      .idle     (core_idle),
      .done     (core_done),
      .rsp      (core_rsp)
   );

   // Output register between the core and the response channel.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= core_done;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && core_done) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_granted   = rsp_ff.granted;
   assign rsp_wait_us   = rsp_ff.wait_us;
   assign rsp_wait_fits = rsp_ff.wait_fits;

   // An accepted request keeps the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("request accepted but block idle next cycle");

   // A grant reports no wait and always fits.
   a_grant_no_wait: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted) |-> ((rsp_wait_us == '0) && rsp_wait_fits))
      else $error("granted result with nonzero wait or no fit");

   // With a zero rate a denial waits forever.
   a_zero_rate_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted && (rate_ff == '0)) |-> (rsp_wait_us == '1))
      else $error("zero rate denial without saturated wait");

   // The core never reports done while it is idle.
   a_done_not_idle: assert property (@(posedge clock) disable iff (reset)
      core_done |-> !core_idle)
      else $error("core reports done while idle");

endmodule

### test/tb_token_bucket_rate_limiter.sv
// Self-checking testbench for the token bucket rate limiter: refill, grant, wait and timeout.
`timescale 1ns / 100ps

module tb_token_bucket_rate_limiter;
   import tbrl_pkg::*;

   localparam int          CLK_PERIOD   = 10;
   localparam int          RESET_CYCLES = 6;
   localparam int          SETTLE       = 100;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          PHASE_ITEMS  = 110;
   localparam int unsigned RUN_LIMIT    = 1500000;
   localparam logic [TOUT_W-1:0] TOUT_MAX = '1;

   // Block ports.
   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic                  req_operation   = OP_TRY;
   logic [TIME_BITS-1:0]  req_now_us      = '0;
   logic [PCOUNT_W-1:0]   req_permits     = '0;
   logic [TOUT_W-1:0]     req_max_wait_us = '0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic                  rsp_granted;
   logic [WAIT_W-1:0]     rsp_wait_us;
   logic                  rsp_wait_fits;
   logic                  csr_valid       = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_data        = '0;

   // Bucket state as the testbench expects it to be.
   logic [RATE_W-1:0]    bkt_rate  = '0;
   logic [BURST_W-1:0]   bkt_burst = '0;
   logic [63:0]          bkt_level = '0;
   logic [TIME_BITS-1:0] bkt_last  = '0;

   // Responses still owed by the block, oldest first.
   rsp_type              pending_rsps[$];
   rsp_type              want;

   logic [TIME_BITS-1:0] cur_time     = '0;
   bit                   src_idle_en  = 1'b1;
   bit                   sink_idle_en = 1'b1;
   int                   hold_requests = 0;
   int                   hold_seen     = 0;
   int                   hold_left     = 0;
   int                   sink_burst_left = 0;
   int unsigned          cycle_count  = 0;
   int                   mismatches   = 0;
   int                   reqs_sent    = 0;
   int                   rsps_seen    = 0;
   int                   grants       = 0;
   int                   fits_seen    = 0;
   int                   reg_writes   = 0;

   token_bucket_rate_limiter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_now_us      (req_now_us),
      .req_permits     (req_permits),
      .req_max_wait_us (req_max_wait_us),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_granted     (rsp_granted),
      .rsp_wait_us     (rsp_wait_us),
      .rsp_wait_fits   (rsp_wait_fits),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses pending.",
                  cycle_count, pending_rsps.size());
         $display("FAIL token_bucket_rate_limiter");
         $finish;
      end
   end

   // Refill the bucket for one request, then grant or work out the wait.
   function automatic rsp_type bucket_predict(input req_type rq);
      logic [63:0] cap;
      logic [63:0] elapsed;
      logic [63:0] room;
      logic [63:0] need;
      logic [63:0] wait_v;
      logic [63:0] tout;
      rsp_type     res;
      cap     = 64'(bkt_burst) << FRAC_BITS;
      elapsed = (rq.now_us >= bkt_last) ? 64'(rq.now_us - bkt_last) : 64'd0;
      bkt_last = rq.now_us;
      if (bkt_level >= cap) begin
         bkt_level = cap;
      end else if (bkt_rate != '0 && elapsed != 64'd0) begin
         room = cap - bkt_level;
         if (elapsed > room / 64'(bkt_rate))
            bkt_level = cap;
         else if (elapsed * 64'(bkt_rate) >= room)
            bkt_level = cap;
         else
            bkt_level = bkt_level + elapsed * 64'(bkt_rate);
      end
      need = 64'(rq.permits) << FRAC_BITS;
      tout = (rq.operation == OP_TIMEOUT) ? 64'(rq.max_wait_us) : 64'd0;
      if (bkt_level >= need) begin
         bkt_level     = bkt_level - need;
         res.granted   = 1'b1;
         res.wait_us   = '0;
         res.wait_fits = 1'b1;
      end else begin
         if (bkt_rate == '0) begin
            wait_v = 64'hFFFF_FFFF;
         end else begin
            wait_v = (need - bkt_level + 64'(bkt_rate) - 64'd1) / 64'(bkt_rate);
            if (wait_v > 64'hFFFF_FFFF)
               wait_v = 64'hFFFF_FFFF;
         end
         res.granted   = 1'b0;
         res.wait_us   = wait_v[WAIT_W-1:0];
         res.wait_fits = (wait_v <= tout);
      end
      return res;
   endfunction

   function automatic req_type make_request(input logic op, input logic [TIME_BITS-1:0] now,
                                            input logic [PCOUNT_W-1:0] permits,
                                            input logic [TOUT_W-1:0] tout);
      req_type rq;
      rq.operation   = op;
      rq.now_us      = now;
      rq.permits     = permits;
      rq.max_wait_us = tout;
      cur_time       = now;
      return rq;
   endfunction

   // Mostly time moving forward by small steps, with repeats, reversals and big jumps.
   function automatic req_type random_request(input int unsigned step_max);
      logic [TIME_BITS-1:0] now;
      logic [PCOUNT_W-1:0]  permits;
      logic [TOUT_W-1:0]    tout;
      int unsigned          sel;
      sel = $urandom_range(0, 99);
      if (sel < 78)
         now = cur_time + TIME_BITS'($urandom_range(0, step_max));
      else if (sel < 86)
         now = cur_time;
      else if (sel < 92)
         now = cur_time - TIME_BITS'($urandom_range(1, step_max));
      else if (sel < 96)
         now = cur_time + 48'({8'($urandom_range(0, 255)), $urandom()});
      else
         now = {16'($urandom()), $urandom()};
      sel = $urandom_range(0, 99);
      if (sel < 70)
         permits = PCOUNT_W'($urandom_range(0, int'(bkt_burst) / 4 + 2));
      else if (sel < 80)
         permits = bkt_burst;
      else if (sel < 88)
         permits = '0;
      else if (sel < 94)
         permits = bkt_burst + 16'd1;
      else
         permits = PCOUNT_W'($urandom());
      sel = $urandom_range(0, 99);
      if (sel < 30)
         tout = TOUT_W'($urandom_range(0, 4000));
      else if (sel < 50)
         tout = '0;
      else if (sel < 70)
         tout = TOUT_W'($urandom());
      else if (sel < 85)
         tout = TOUT_MAX;
      else
         tout = TOUT_W'($urandom_range(0, 100000));
      return make_request($urandom_range(0, 1) ? OP_TIMEOUT : OP_TRY, now, permits, tout);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                  input logic [63:0] got_v);
      $display("Mismatch at %0t: %s expected %0h, got %0h (response %0d)",
               $realtime, what, exp_v, got_v, rsps_seen);
      mismatches++;
   endtask

   // Offer one request, with an optional gap first, and record what it should return.
   task automatic send_request(input req_type rq);
      if (src_idle_en && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_operation   <= rq.operation;
      req_now_us      <= rq.now_us;
      req_permits     <= rq.permits;
      req_max_wait_us <= rq.max_wait_us;
      do @(posedge clock); while (req_stall);
      pending_rsps.push_back(bucket_predict(rq));
      reqs_sent++;
   endtask

   // Stop offering and wait until every pending response has come back.
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_REFILL_RATE) begin
         bkt_rate = data[RATE_W-1:0];
      end else if (idx == REG_BURST_LIMIT) begin
         bkt_burst = data[BURST_W-1:0];
         if (bkt_level > (64'(bkt_burst) << FRAC_BITS))
            bkt_level = 64'(bkt_burst) << FRAC_BITS;
      end
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [RATE_W-1:0] rate, input logic [BURST_W-1:0] burst);
      wait_drain();
      csr_write(REG_REFILL_RATE, CSR_DATA_W'(rate));
      csr_write(REG_BURST_LIMIT, CSR_DATA_W'(burst));
   endtask

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("response with no request pending, wait_us", 64'd0,
                            64'(rsp_wait_us));
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_granted !== want.granted)
               report_mismatch("granted", 64'(want.granted), 64'(rsp_granted));
            if (rsp_wait_us !== want.wait_us)
               report_mismatch("wait_us", 64'(want.wait_us), 64'(rsp_wait_us));
            if (rsp_wait_fits !== want.wait_fits)
               report_mismatch("wait_fits", 64'(want.wait_fits), 64'(rsp_wait_fits));
            grants    += int'(want.granted);
            fits_seen += int'(want.wait_fits);
         end
         rsps_seen++;
      end
   end

   // Response side stalls: a requested long hold-off, or random bursts when enabled.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (sink_burst_left > 0) begin
         sink_burst_left--;
         rsp_stall <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
         sink_burst_left = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Right after reset: empty bucket, zero rate and zero burst.
   task automatic test_reset_state();
      send_request(make_request(OP_TRY, 48'd0, 16'd0, 31'd0));
      send_request(make_request(OP_TIMEOUT, 48'd5, 16'd1, TOUT_MAX));
   endtask

   // Hand-picked corners: cap overflow, denials, rounding, time reversal, saturation.
   task automatic test_special_cases();
      set_config(32'h0100_0000, 16'd10);
      send_request(make_request(OP_TRY, 48'd1000, 16'd10, 31'd0));
      send_request(make_request(OP_TRY, 48'd1000, 16'd1, 31'd0));
      send_request(make_request(OP_TIMEOUT, 48'd1002, 16'd5, 31'd0));
      send_request(make_request(OP_TIMEOUT, 48'd1002, 16'd5, 31'd3));
      send_request(make_request(OP_TRY, 48'd500, 16'd1, 31'd0));
      send_request(make_request(OP_TRY, 48'd501, 16'd0, 31'd0));
      send_request(make_request(OP_TIMEOUT, 48'd600, 16'd11, TOUT_MAX));
      send_request(make_request(OP_TIMEOUT, 48'd700, 16'hFFFF, TOUT_MAX));
      // A rate of three quarters of a permit per microsecond forces rounding up.
      set_config(32'h00C0_0000, 16'd10);
      send_request(make_request(OP_TIMEOUT, 48'd800, 16'd10, 31'd2));
      send_request(make_request(OP_TIMEOUT, 48'd801, 16'd2, 31'd2));
      send_request(make_request(OP_TIMEOUT, 48'd801, 16'd2, 31'd1));
      // The smallest rate pushes the wait past 32 bits.
      set_config(32'd1, 16'hFFFF);
      send_request(make_request(OP_TIMEOUT, 48'd802, 16'hFFFF, TOUT_MAX));
      set_config(32'hFFFF_FFFF, 16'hFFFF);
      send_request(make_request(OP_TRY, 48'hFFFF_FFFF_FFFF, 16'd0, 31'd0));
      // Lowering the burst limit clamps a full bucket at once.
      wait_drain();
      csr_write(REG_BURST_LIMIT, 32'd3);
      send_request(make_request(OP_TIMEOUT, 48'hFFFF_FFFF_FFFF, 16'd3, 31'd0));
      send_request(make_request(OP_TIMEOUT, 48'hFFFF_FFFF_FFFF, 16'd1, TOUT_MAX));
      send_request(make_request(OP_TRY, 48'd0, 16'd1, 31'd0));
      send_request(make_request(OP_TRY, 48'd1, 16'd3, 31'd0));
   endtask

   // Random traffic under a series of register settings, extremes among them.
   task automatic test_random_phases();
      logic [RATE_W-1:0]  rate;
      logic [BURST_W-1:0] burst;
      int unsigned        step_max;
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: begin rate = 32'h0100_0000; burst = 16'd16; step_max = 8; end
            1: begin rate = 32'h0001_0000; burst = 16'd8; step_max = 2000; end
            2: begin rate = 32'h0000_0000; burst = 16'd32; step_max = 500; end
            3: begin rate = 32'hFFFF_FFFF; burst = 16'hFFFF; step_max = 4; end
            4: begin rate = 32'd1; burst = 16'd4; step_max = 32'h0200_0000; end
            5: begin rate = $urandom(); burst = 16'($urandom()); step_max = 100; end
            6: begin rate = 32'h0100_0000; burst = 16'd0; step_max = 100; end
            default: begin
               rate     = $urandom_range(32'h0000_0400, 32'h0400_0000);
               burst    = 16'($urandom_range(1, 200));
               step_max = $urandom_range(10, 5000);
            end
         endcase
         set_config(rate, burst);
         src_idle_en  = ($urandom_range(0, 3) != 0);
         sink_idle_en = ($urandom_range(0, 3) != 0);
         repeat (PHASE_ITEMS) send_request(random_request(step_max));
      end
      src_idle_en  = 1'b1;
      sink_idle_en = 1'b1;
   endtask

   // Hold the response side off for a long stretch while requests keep coming.
   task automatic test_full_backpressure();
      set_config(32'h0010_0000, 16'd40);
      src_idle_en = 1'b0;
      hold_requests++;
      repeat (40) send_request(random_request(200));
      src_idle_en = 1'b1;
   endtask

   // Let everything drain between short bursts of requests.
   task automatic test_drain_pause();
      repeat (3) begin
         repeat (15) send_request(random_request(300));
         wait_drain();
      end
   endtask

   // Closing stretch with neither side idling.
   task automatic test_no_idle();
      set_config(32'h0040_0000, 16'd24);
      src_idle_en  = 1'b0;
      sink_idle_en = 1'b0;
      repeat (160) send_request(random_request(50));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_special_cases();
      test_random_phases();
      test_full_backpressure();
      test_drain_pause();
      test_no_idle();

      wait_drain();
      repeat (SETTLE) @(posedge clock);
      if (pending_rsps.size() != 0)
         report_mismatch("responses never returned, count", 64'd0, 64'(pending_rsps.size()));
      $display("Sent %0d requests, checked %0d responses (%0d granted, %0d within timeout).",
               reqs_sent, rsps_seen, grants, fits_seen);
      $display("Covered %0d register writes, corner cases, a long hold-off and drain pauses.",
               reg_writes);
      if (mismatches == 0)
         $display("PASS token_bucket_rate_limiter");
      else
         $display("FAIL token_bucket_rate_limiter");
      $finish;
   end

endmodule
